// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the deframer modules.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ELD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define ELD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define ELD_ASSERT_IMPL(label, ante, cons)
`define ELD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/eld_pkg.sv =====
// Types and constants for the event log record deframer.
// Used by every module of the block; depends on nothing else.
package eld_pkg;

    // Sync word that opens every record, and header geometry.
    localparam logic [31:0] SYNC_WORD      = 32'hEDA1DA01;
    localparam logic [4:0]  HDR_LAST_BYTE  = 5'd23;
    localparam logic [4:0]  HDR_TIME_START = 5'd8;
    localparam logic [4:0]  HDR_CLEN_START = 5'd16;
    localparam logic [4:0]  HDR_DLEN_START = 5'd20;

    // Parser phase, one-hot.
    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_CHANNEL = 4'b0100,
        PH_DATA    = 4'b1000
    } eld_phase_t;

    // Kind of result word.
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_CHANNEL = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_TRUNC   = 2'd3
    } eld_kind_t;

    // One input word of the log stream.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       stream_end;
    } eld_in_t;

    // One result word.
    typedef struct packed {
        eld_kind_t          result_kind;
        logic signed [63:0] event_number;
        logic signed [63:0] time_stamp;
        logic [31:0]        channel_length;
        logic [31:0]        data_length;
        logic [7:0]         byte_out;
        logic               last_of_section;
        logic               last_of_event;
    } eld_out_t;

    // Parser outcome for the word in the input register.
    typedef struct packed {
        logic     valid;
        eld_out_t word;
    } eld_step_t;

endpackage

// ===== rtl/eld_core.sv =====
// Deframer state machine: sync hunt, header capture and byte pass-through.
// Depends on eld_pkg and assert_macros.svh.
`include "assert_macros.svh"

module eld_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  eld_pkg::eld_in_t   word,
    output eld_pkg::eld_step_t outcome
);

    eld_pkg::eld_phase_t phase_reg, phase_next;
    logic [31:0]         sync_window_reg, sync_window_next;
    logic [4:0]          hdr_cnt_reg, hdr_cnt_next;
    logic [63:0]         event_num_reg, event_num_next;
    logic [63:0]         time_reg, time_next;
    logic [31:0]         chan_len_reg, chan_len_next;
    logic [31:0]         data_len_reg, data_len_next;
    logic [31:0]         remaining_reg, remaining_next;

    // Next state and result for the current word. The result is always
    // computed; the state only moves when the word is consumed.
    always_comb
    begin
        logic [31:0] window;
        logic        last;
        phase_next       = phase_reg;
        sync_window_next = sync_window_reg;
        hdr_cnt_next     = hdr_cnt_reg;
        event_num_next   = event_num_reg;
        time_next        = time_reg;
        chan_len_next    = chan_len_reg;
        data_len_next    = data_len_reg;
        remaining_next   = remaining_reg;
        outcome          = '0;
        window           = {sync_window_reg[23:0], word.byte_value};
        last             = (remaining_reg <= 32'd1);

        if (word.stream_end)
        begin
            // End of stream: a record in progress is reported as truncated.
            if (phase_reg != eld_pkg::PH_HUNT)
            begin
                outcome.valid              = 1'b1;
                outcome.word.result_kind   = eld_pkg::KIND_TRUNC;
                outcome.word.last_of_event = 1'b1;
            end
            phase_next       = eld_pkg::PH_HUNT;
            sync_window_next = '0;
            hdr_cnt_next     = '0;
            remaining_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                eld_pkg::PH_HUNT:
                begin
                    // Slide the window; a match starts a fresh header.
                    if (window == eld_pkg::SYNC_WORD)
                    begin
                        sync_window_next = '0;
                        phase_next       = eld_pkg::PH_HEADER;
                        hdr_cnt_next     = '0;
                    end
                    else
                    begin
                        sync_window_next = window;
                    end
                end
                eld_pkg::PH_HEADER:
                begin
                    // Shift the byte into the field that the count selects.
                    if (hdr_cnt_reg < eld_pkg::HDR_TIME_START)
                        event_num_next = {event_num_reg[55:0], word.byte_value};
                    else if (hdr_cnt_reg < eld_pkg::HDR_CLEN_START)
                        time_next = {time_reg[55:0], word.byte_value};
                    else if (hdr_cnt_reg < eld_pkg::HDR_DLEN_START)
                        chan_len_next = {chan_len_reg[23:0], word.byte_value};
                    else
                        data_len_next = {data_len_reg[23:0], word.byte_value};

                    if (hdr_cnt_reg == eld_pkg::HDR_LAST_BYTE)
                    begin
                        hdr_cnt_next             = '0;
                        outcome.valid            = 1'b1;
                        outcome.word.result_kind = eld_pkg::KIND_HEADER;
                        if (chan_len_next != '0)
                        begin
                            phase_next     = eld_pkg::PH_CHANNEL;
                            remaining_next = chan_len_next;
                        end
                        else if (data_len_next != '0)
                        begin
                            phase_next     = eld_pkg::PH_DATA;
                            remaining_next = data_len_next;
                        end
                        else
                        begin
                            // Both sections empty: the header ends the record.
                            outcome.word.last_of_event = 1'b1;
                            phase_next                 = eld_pkg::PH_HUNT;
                            sync_window_next           = '0;
                            remaining_next             = '0;
                        end
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 5'd1;
                    end
                end
                eld_pkg::PH_CHANNEL:
                begin
                    // Channel-name byte; an empty payload ends the record here.
                    outcome.valid                = 1'b1;
                    outcome.word.result_kind     = eld_pkg::KIND_CHANNEL;
                    outcome.word.byte_out        = word.byte_value;
                    outcome.word.last_of_section = last;
                    outcome.word.last_of_event   = last && (data_len_reg == '0);
                    if (!last)
                    begin
                        remaining_next = remaining_reg - 32'd1;
                    end
                    else if (data_len_reg != '0)
                    begin
                        phase_next     = eld_pkg::PH_DATA;
                        remaining_next = data_len_reg;
                    end
                    else
                    begin
                        phase_next       = eld_pkg::PH_HUNT;
                        sync_window_next = '0;
                        hdr_cnt_next     = '0;
                        remaining_next   = '0;
                    end
                end
                eld_pkg::PH_DATA:
                begin
                    // Payload byte; the final one closes the record.
                    outcome.valid                = 1'b1;
                    outcome.word.result_kind     = eld_pkg::KIND_PAYLOAD;
                    outcome.word.byte_out        = word.byte_value;
                    outcome.word.last_of_section = last;
                    outcome.word.last_of_event   = last;
                    if (!last)
                    begin
                        remaining_next = remaining_reg - 32'd1;
                    end
                    else
                    begin
                        phase_next       = eld_pkg::PH_HUNT;
                        sync_window_next = '0;
                        hdr_cnt_next     = '0;
                        remaining_next   = '0;
                    end
                end
                default:
                begin
                    phase_next       = eld_pkg::PH_HUNT;
                    sync_window_next = '0;
                    hdr_cnt_next     = '0;
                    remaining_next   = '0;
                end
            endcase
        end

        // Header, channel and payload words carry the held header fields.
        if (outcome.word.result_kind != eld_pkg::KIND_TRUNC)
        begin
            outcome.word.event_number   = event_num_next;
            outcome.word.time_stamp     = time_next;
            outcome.word.channel_length = chan_len_next;
            outcome.word.data_length    = data_len_next;
        end
    end

    // State registers advance only on a consumed word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= eld_pkg::PH_HUNT;
            sync_window_reg <= '0;
            hdr_cnt_reg     <= '0;
            event_num_reg   <= '0;
            time_reg        <= '0;
            chan_len_reg    <= '0;
            data_len_reg    <= '0;
            remaining_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            sync_window_reg <= sync_window_next;
            hdr_cnt_reg     <= hdr_cnt_next;
            event_num_reg   <= event_num_next;
            time_reg        <= time_next;
            chan_len_reg    <= chan_len_next;
            data_len_reg    <= data_len_next;
            remaining_reg   <= remaining_next;
        end
    end

    // The header count only moves while a header is being collected.
    `ELD_ASSERT_IMPL(a_hdr_cnt_phase, hdr_cnt_reg != '0, phase_reg == eld_pkg::PH_HEADER)
    // The sync window is only filled while hunting.
    `ELD_ASSERT_IMPL(a_window_phase, sync_window_reg != '0, phase_reg == eld_pkg::PH_HUNT)
    // A byte section in progress always has bytes left to pass.
    `ELD_ASSERT_IMPL(a_remaining_phase, 1'b1,
        (phase_reg == eld_pkg::PH_CHANNEL || phase_reg == eld_pkg::PH_DATA)
        == (remaining_reg != '0))

endmodule

// ===== rtl/eld_out_reg.sv =====
// Result register of the deframer, holding one word until the consumer takes it.
// Depends on eld_pkg and assert_macros.svh.
`include "assert_macros.svh"

module eld_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  eld_pkg::eld_step_t outcome,
    input  logic               stall,
    output logic               ready,
    output logic               valid,
    output eld_pkg::eld_out_t  word
);

    logic              valid_reg;
    eld_pkg::eld_out_t word_reg;
    logic              take;

    // The register can take a new word when empty or being drained.
    assign ready = !valid_reg || !stall;
    assign take  = load && outcome.valid;
    assign valid = valid_reg;
    assign word  = word_reg;

    // Valid flag: set on a new result, cleared once the word is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (ready)
            valid_reg <= 1'b0;
    end

    // Result word storage.
    always_ff @(posedge clk)
    begin
        if (take)
            word_reg <= outcome.word;
    end

    // A loaded result is always presented in the following cycle.
    `ELD_ASSERT_NEXT(a_load_shows, take, valid_reg)

endmodule

// ===== rtl/event_log_record_deframer.sv =====
// Event log record deframer: an accepted word reaches its result word through the input register, then
// the result register; throughput is one word per clock while the result side does not stall.
// Words that give no result pass the input register even while the result side stalls.
// Reset (rst_n, asynchronous, active low) empties both registers and restarts the sync hunt.
// Depends on eld_pkg, eld_core and eld_out_reg.
module event_log_record_deframer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              log_valid,
    output logic              log_stall,
    input  eld_pkg::eld_in_t  log_word,
    output logic              res_valid,
    input  logic              res_stall,
    output eld_pkg::eld_out_t res_word
);

    logic               in_valid_reg;
    eld_pkg::eld_in_t   in_word_reg;
    eld_pkg::eld_step_t outcome;
    logic               out_ready;
    logic               go;
    logic               accept;

    // The held word moves on when its result, if any, has room.
    assign go        = in_valid_reg && (out_ready || !outcome.valid);
    assign log_stall = in_valid_reg && !go;
    assign accept    = log_valid && !log_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (go)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_word_reg <= log_word;
    end

    // Parser.
    eld_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (go),
        .word    (in_word_reg),
        .outcome (outcome)
    );

    // Result register.
    eld_out_reg u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (go),
        .outcome (outcome),
        .stall   (res_stall),
        .ready   (out_ready),
        .valid   (res_valid),
        .word    (res_word)
    );

endmodule
